FILE: design/fmp_pkg.sv
// fmp_pkg: shared widths, microcode types and the control store
// of the fibonacci matrix-power block. no dependencies.

package fmp_pkg;

    localparam int INDEX_BITS = 32;
    localparam int EXP_BITS   = INDEX_BITS + 1;
    localparam int CNT_W      = $clog2(EXP_BITS);
    localparam int VAL_W      = 16;

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [EXP_BITS-1:0]   t_exp;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [VAL_W-1:0]      t_val;
    typedef logic [1:0]            t_pc;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_LOAD   = 3'd1,
        OP_SQUARE = 3'd2,
        OP_MULQ   = 3'd3,
        OP_EMIT   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        C_NONE     = 2'd0,
        C_IN_FIRE  = 2'd1,
        C_OUT_FREE = 2'd2,
        C_BIT      = 2'd3
    } t_cond;

    // step addresses of the control store
    localparam t_pc ST_WAIT = 2'd0;
    localparam t_pc ST_SQR  = 2'd1;
    localparam t_pc ST_MULQ = 2'd2;
    localparam t_pc ST_EMIT = 2'd3;

    // branch: cond true -> hit_pc; else with adv: last ? exit_pc : loop_pc
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  adv;
        t_pc   hit_pc;
        t_pc   loop_pc;
        t_pc   exit_pc;
    } t_uword;

    // sequencer -> datapath
    typedef struct packed {
        t_op  op;
        logic en;
        logic adv;
        logic take;
    } t_ctrl;

    // datapath and ports -> sequencer
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic bit_msb;
        logic last;
    } t_stat;

    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        begin
            w = '{OP_NOP, C_NONE, 1'b0, ST_WAIT, ST_WAIT, ST_WAIT};
            case (pc)
                ST_WAIT: w = '{OP_LOAD,   C_IN_FIRE,  1'b0, ST_SQR,  ST_WAIT, ST_WAIT};
                ST_SQR:  w = '{OP_SQUARE, C_BIT,      1'b1, ST_MULQ, ST_SQR,  ST_EMIT};
                ST_MULQ: w = '{OP_MULQ,   C_NONE,     1'b1, ST_WAIT, ST_SQR,  ST_EMIT};
                ST_EMIT: w = '{OP_EMIT,   C_OUT_FREE, 1'b0, ST_WAIT, ST_EMIT, ST_EMIT};
                default: w = '{OP_NOP,    C_NONE,     1'b0, ST_WAIT, ST_WAIT, ST_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: design/fmp_ifs.sv
// fmp_in_if / fmp_out_if: valid-ready channels of the fibonacci block
// depends on fmp_pkg for the payload types

interface fmp_in_if;
    logic              valid;
    logic              ready;
    fmp_pkg::t_index   index;
    modport source (output valid, output index, input ready);
    modport sink   (input valid, input index, output ready);
endinterface

interface fmp_out_if;
    logic              valid;
    logic              ready;
    fmp_pkg::t_val     fib_value;
    modport source (output valid, output fib_value, input ready);
    modport sink   (input valid, input fib_value, output ready);
endinterface

FILE: design/fmp_seq.sv
// fmp_seq: step counter and control-store readout with conditional jumps
// depends on fmp_pkg (ucode table, control and status structs)

module fmp_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fmp_pkg::t_stat i_stat,
    output fmp_pkg::t_ctrl o_ctrl
);
    import fmp_pkg::*;

    t_pc    r_pc, n_pc;
    t_uword w_word;
    logic   w_hit;

    assign w_word = ucode(r_pc);

    always_comb begin
        case (w_word.cond)
            C_NONE:     w_hit = 1'b0;
            C_IN_FIRE:  w_hit = i_stat.in_fire;
            C_OUT_FREE: w_hit = i_stat.out_free;
            C_BIT:      w_hit = i_stat.bit_msb;
            default:    w_hit = 1'b0;
        endcase
    end

    always_comb begin
        if (w_hit) begin
            n_pc = w_word.hit_pc;
        end else if (w_word.adv && i_stat.last) begin
            n_pc = w_word.exit_pc;
        end else begin
            n_pc = w_word.loop_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // load and emit only act once their handshake condition holds
    assign o_ctrl.op   = w_word.op;
    assign o_ctrl.en   = (w_word.op == OP_LOAD || w_word.op == OP_EMIT) ? w_hit : 1'b1;
    assign o_ctrl.adv  = w_word.adv && !w_hit;
    assign o_ctrl.take = (w_word.op == OP_LOAD);

endmodule

FILE: design/fmp_dp.sv
// fmp_dp: 2x2 matrix registers, exponent shifter, bit counter, result register
// depends on fmp_pkg (types, control struct)

module fmp_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fmp_pkg::t_ctrl  i_ctrl,
    input  fmp_pkg::t_index i_index,
    input  logic            i_out_ready,
    output logic            o_bit_msb,
    output logic            o_last,
    output logic            o_out_free,
    output logic            o_out_valid,
    output fmp_pkg::t_val   o_fib_value
);
    import fmp_pkg::*;

    t_val r_a, r_b, r_c, r_d;
    t_val n_a, n_b, n_c, n_d;
    t_exp r_exp;
    t_cnt r_cnt;
    logic r_out_valid;
    t_val r_out_data;
    t_val w_sa, w_sb, w_sc, w_sd;

    // square, low 16 bits of each product are all that survive
    assign w_sa = t_val'(r_a * r_a) + t_val'(r_b * r_c);
    assign w_sb = t_val'(r_a * r_b) + t_val'(r_b * r_d);
    assign w_sc = t_val'(r_c * r_a) + t_val'(r_d * r_c);
    assign w_sd = t_val'(r_c * r_b) + t_val'(r_d * r_d);

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_c = r_c;
        n_d = r_d;
        case (i_ctrl.op)
            OP_LOAD: begin
                n_a = t_val'(1);
                n_b = '0;
                n_c = '0;
                n_d = t_val'(1);
            end
            OP_SQUARE: begin
                n_a = w_sa;
                n_b = w_sb;
                n_c = w_sc;
                n_d = w_sd;
            end
            // times [[0,1],[1,1]]
            OP_MULQ: begin
                n_a = r_b;
                n_b = r_a + r_b;
                n_c = r_d;
                n_d = r_c + r_d;
            end
            default: begin
                n_a = r_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
        end
        if (i_ctrl.en && i_ctrl.op == OP_LOAD) begin
            r_exp <= {1'b0, i_index} + t_exp'(1);
            r_cnt <= t_cnt'(EXP_BITS - 1);
        end else if (i_ctrl.adv) begin
            r_exp <= {r_exp[EXP_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - t_cnt'(1);
        end
        if (i_ctrl.en && i_ctrl.op == OP_EMIT) begin
            r_out_data <= r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.en && i_ctrl.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_bit_msb   = r_exp[EXP_BITS-1];
    assign o_last      = (r_cnt == '0);
    assign o_out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_fib_value = r_out_data;

endmodule

FILE: design/fibonacci_mod_2_16_matrix_power.sv
// fibonacci_mod_2_16_matrix_power: F(n) mod 2^16 by square-and-multiply of [[0,1],[1,1]]
// depends on fmp_pkg, fmp_ifs, fmp_seq, fmp_dp
//
//   channel  dir  payload            beats per item
//   i_in     in   index[31:0]        1
//   o_out    out  fib_value[15:0]    1
//
// for each item the loop does one
// matrix square per exponent bit plus one multiply step per set bit
// the result sits in an output register, so the next index is taken while it waits
// o_out stalls hold the sequencer in its emit step only when that register is full
// reset (synchronous, active low) returns the step counter to wait and empties o_out

module fibonacci_mod_2_16_matrix_power (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fmp_in_if.sink    i_in,
    fmp_out_if.source o_out
);
    import fmp_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_bit_msb;
    logic  w_last;
    logic  w_out_free;
    logic  w_in_fire;

    assign i_in.ready = w_ctrl.take;
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign w_stat.in_fire  = w_in_fire;
    assign w_stat.out_free = w_out_free;
    assign w_stat.bit_msb  = w_bit_msb;
    assign w_stat.last     = w_last;

    fmp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    fmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_index     (i_in.index),
        .i_out_ready (o_out.ready),
        .o_bit_msb   (w_bit_msb),
        .o_last      (w_last),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out.valid),
        .o_fib_value (o_out.fib_value)
    );

    // the sequencer is busy in the cycle after taking an index
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_in.ready)
        else $error("index taken twice in a row");

    // a new result beat only ever comes from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_ctrl.op == OP_EMIT && w_ctrl.en))
        else $error("result appeared outside emit");

    // the exponent loop never advances past its last bit
    a_adv_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.adv && w_last) |=> !(w_ctrl.op == OP_SQUARE || w_ctrl.op == OP_MULQ))
        else $error("exponent loop ran past last bit");

endmodule
